@@ sv/contrast_stretch_8bit_core_macros.svh @@
// ----------------------------------------------------------------------------
// contrast_stretch_8bit_core assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef CONTRAST_STRETCH_8BIT_CORE_MACROS_SVH
`define CONTRAST_STRETCH_8BIT_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CS8_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cs8 assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define CS8_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cs8 assertion failed");

`endif

@@ sv/cs8_pkg.sv @@
// ----------------------------------------------------------------------------
// cs8_pkg
// Constants and interface types shared by the contrast stretch core.
// ----------------------------------------------------------------------------
`default_nettype none

package cs8_pkg;

  // Buffer capacity in pixels
  localparam int MAX_PIXELS = 4096;
  localparam int ADDR_W     = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int CNT_W      = $clog2(MAX_PIXELS + 1);

  localparam int PIX_W      = 8;
  localparam int NUM_W      = 17;   // 510*255 + 255 fits in 17 bits
  localparam int QSTEPS     = 8;    // quotient bits, one per cycle
  localparam int STEP_W     = $clog2(QSTEPS);

  localparam logic [PIX_W-1:0] PIX_MIN_INIT = 8'd255;
  localparam logic [PIX_W-1:0] PIX_MAX_INIT = 8'd0;
  localparam logic [PIX_W-1:0] PIX_FLAT     = 8'd128;
  localparam logic [NUM_W-1:0] SCALE_2X     = 17'd510;

  // Buffer access from the control logic
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [PIX_W-1:0]  wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } pbuf_req_t;

  // Stretch unit request
  typedef struct packed {
    logic             start;
    logic [PIX_W-1:0] pix;
    logic [PIX_W-1:0] lo;
    logic [PIX_W-1:0] span;
  } stretch_req_t;

  // Stretch unit response
  typedef struct packed {
    logic             done;
    logic [PIX_W-1:0] quo;
  } stretch_rsp_t;

endpackage

`default_nettype wire

@@ sv/contrast_stretch_8bit_core.sv @@
// ----------------------------------------------------------------------------
// contrast_stretch_8bit_core
// Min/max contrast stretch over a buffered 8-bit image.
// ----------------------------------------------------------------------------
// Load transactions (command 0) store a pixel and update the running min and
// max; a load after fetching has begun starts a new image,
// and loads past MAX_PIXELS are dropped and flagged. Fetch transactions
// (command 1) return the next stored pixel stretched to 0..255 with
// round-half-up. For a pixel fetch the buffer read is registered at the
// accepting edge, then the stretch unit sets up the numerator, the
// bit-per-cycle divider produces its eight quotient bits and the result is
// loaded into the output register. Nothing is taken until then. A flat image
// (min equals max) registers its result at the edge that follows the
// accepting edge, and an empty fetch registers its result at the accepting
// edge. The result sits in an output register; loads are still taken while
// it waits, fetches are held until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

`include "contrast_stretch_8bit_core_macros.svh"

module contrast_stretch_8bit_core (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic                      in_command,
  input  wire logic [cs8_pkg::PIX_W-1:0] in_pixel_in,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [cs8_pkg::PIX_W-1:0]      out_pixel_out,
  output logic                           out_last,
  output logic                           out_empty_res,
  output logic                           out_overflow
);
  import cs8_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_DIV  = 3'b100
  } state_t;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_FETCH = 1'b1;

  state_t           state_r,    state_nxt;
  logic [CNT_W-1:0] count_r,    count_nxt;
  logic [CNT_W-1:0] rdpos_r,    rdpos_nxt;
  logic [PIX_W-1:0] min_r,      min_nxt;
  logic [PIX_W-1:0] max_r,      max_nxt;
  logic             drain_r,    drain_nxt;
  logic             ovf_r,      ovf_nxt;
  logic             last_r,     last_nxt;

  logic             ov_r,       ov_nxt;
  logic [PIX_W-1:0] opix_r,     opix_nxt;
  logic             olast_r,    olast_nxt;
  logic             oempty_r,   oempty_nxt;
  logic             oovf_r,     oovf_nxt;

  logic             in_fire;
  logic             out_fire;
  logic             empty;
  logic [PIX_W-1:0] span;
  logic [PIX_W-1:0] rdata;

  pbuf_req_t        buf_req;
  stretch_req_t     st_req;
  stretch_rsp_t     st_rsp;

  // buffer and stretch unit
  cs8_pixel_buf u_buf (
    .clk     (clk),
    .req     (buf_req),
    .rdata_r (rdata)
  );

  cs8_stretch u_stretch (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (st_req),
    .rsp   (st_rsp)
  );

  // handshake
  assign in_stall = (state_r != ST_IDLE) || (ov_r && (in_command == CMD_FETCH));
  assign in_fire  = in_valid && !in_stall;
  assign out_fire = ov_r && !out_stall;
  assign empty    = (rdpos_r >= count_r);
  assign span     = max_r - min_r;

  // control and state update
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    rdpos_nxt  = rdpos_r;
    min_nxt    = min_r;
    max_nxt    = max_r;
    drain_nxt  = drain_r;
    ovf_nxt    = ovf_r;
    last_nxt   = last_r;
    ov_nxt     = ov_r && !out_fire;
    opix_nxt   = opix_r;
    olast_nxt  = olast_r;
    oempty_nxt = oempty_r;
    oovf_nxt   = oovf_r;
    buf_req    = '0;
    st_req     = '0;
    st_req.pix  = rdata;
    st_req.lo   = min_r;
    st_req.span = span;

    case (state_r)
      ST_IDLE: begin
        if (in_fire && (in_command == CMD_LOAD)) begin
          if (drain_r) begin
            // new image: first pixel goes to entry zero
            buf_req.we    = 1'b1;
            buf_req.waddr = '0;
            buf_req.wdata = in_pixel_in;
            count_nxt     = CNT_W'(1);
            rdpos_nxt     = '0;
            min_nxt       = in_pixel_in;
            max_nxt       = in_pixel_in;
            drain_nxt     = 1'b0;
            ovf_nxt       = 1'b0;
          end else if (count_r < CNT_W'(MAX_PIXELS)) begin
            buf_req.we    = 1'b1;
            buf_req.waddr = count_r[ADDR_W-1:0];
            buf_req.wdata = in_pixel_in;
            count_nxt     = count_r + CNT_W'(1);
            if (in_pixel_in < min_r) begin
              min_nxt = in_pixel_in;
            end
            if (in_pixel_in > max_r) begin
              max_nxt = in_pixel_in;
            end
          end else begin
            ovf_nxt = 1'b1;
          end
        end else if (in_fire) begin
          if (empty) begin
            // nothing pending: flag and leave state alone
            ov_nxt     = 1'b1;
            opix_nxt   = '0;
            olast_nxt  = 1'b0;
            oempty_nxt = 1'b1;
            oovf_nxt   = ovf_r;
          end else begin
            buf_req.re    = 1'b1;
            buf_req.raddr = rdpos_r[ADDR_W-1:0];
            last_nxt      = ((rdpos_r + CNT_W'(1)) == count_r);
            rdpos_nxt     = rdpos_r + CNT_W'(1);
            drain_nxt     = 1'b1;
            state_nxt     = ST_READ;
          end
        end
      end

      ST_READ: begin
        if (max_r <= min_r) begin
          // flat image
          ov_nxt     = 1'b1;
          opix_nxt   = PIX_FLAT;
          olast_nxt  = last_r;
          oempty_nxt = 1'b0;
          oovf_nxt   = ovf_r;
          state_nxt  = ST_IDLE;
        end else begin
          st_req.start = 1'b1;
          state_nxt    = ST_DIV;
        end
      end

      ST_DIV: begin
        if (st_rsp.done) begin
          ov_nxt     = 1'b1;
          opix_nxt   = st_rsp.quo;
          olast_nxt  = last_r;
          oempty_nxt = 1'b0;
          oovf_nxt   = ovf_r;
          state_nxt  = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      rdpos_r <= '0;
      min_r   <= PIX_MIN_INIT;
      max_r   <= PIX_MAX_INIT;
      drain_r <= 1'b0;
      ovf_r   <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      rdpos_r <= rdpos_nxt;
      min_r   <= min_nxt;
      max_r   <= max_nxt;
      drain_r <= drain_nxt;
      ovf_r   <= ovf_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    last_r   <= last_nxt;
    opix_r   <= opix_nxt;
    olast_r  <= olast_nxt;
    oempty_r <= oempty_nxt;
    oovf_r   <= oovf_nxt;
  end

  assign out_valid     = ov_r;
  assign out_pixel_out = opix_r;
  assign out_last      = olast_r;
  assign out_empty_res = oempty_r;
  assign out_overflow  = oovf_r;

  // checks
  `CS8_ASSERT_SAME(a_count_cap, 1'b1, count_r <= CNT_W'(MAX_PIXELS))
  `CS8_ASSERT_SAME(a_rdpos_le_count, 1'b1, rdpos_r <= count_r)
  `CS8_ASSERT_SAME(a_empty_zero, ov_r && oempty_r, (opix_r == '0) && !olast_r)
  `CS8_ASSERT_SAME(a_done_in_div, st_rsp.done, state_r == ST_DIV)
  `CS8_ASSERT_NEXT(a_fetch_reads, in_fire && (in_command == CMD_FETCH) && !empty,
                   (state_r == ST_READ) && drain_r)

endmodule

`default_nettype wire

@@ sv/cs8_pixel_buf.sv @@
// ----------------------------------------------------------------------------
// cs8_pixel_buf
// Pixel buffer: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cs8_pixel_buf (
  input  wire logic                      clk,
  input  wire cs8_pkg::pbuf_req_t        req,
  output logic [cs8_pkg::PIX_W-1:0]      rdata_r
);
  import cs8_pkg::*;

  logic [PIX_W-1:0] mem [MAX_PIXELS];

  // write port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata_r <= mem[req.raddr];
    end
  end

endmodule

`default_nettype wire

@@ sv/cs8_stretch.sv @@
// ----------------------------------------------------------------------------
// cs8_stretch
// Scales one pixel: floor((510*(p-lo) + span) / (2*span)), one quotient bit
// per cycle by restoring division.
// ----------------------------------------------------------------------------
`default_nettype none

module cs8_stretch (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire cs8_pkg::stretch_req_t req,
  output cs8_pkg::stretch_rsp_t      rsp
);
  import cs8_pkg::*;

  logic              busy_r,  busy_nxt;
  logic              done_r,  done_nxt;
  logic [STEP_W-1:0] step_r,  step_nxt;
  logic [NUM_W-1:0]  rem_r,   rem_nxt;
  logic [NUM_W-1:0]  dsh_r,   dsh_nxt;
  logic [PIX_W-1:0]  quo_r,   quo_nxt;
  logic [PIX_W-1:0]  diff;
  logic              fits;

  // clamp below the minimum (cannot happen for stored pixels)
  assign diff = (req.pix >= req.lo) ? (req.pix - req.lo) : '0;
  assign fits = (rem_r >= dsh_r);

  // numerator setup, then one compare/subtract per cycle
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    dsh_nxt  = dsh_r;
    quo_nxt  = quo_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      rem_nxt  = NUM_W'(diff) * SCALE_2X + NUM_W'(req.span);
      // 2*span shifted up by QSTEPS-1
      dsh_nxt  = NUM_W'({req.span, 1'b0}) << (QSTEPS - 1);
      quo_nxt  = '0;
    end else if (busy_r) begin
      if (fits) begin
        rem_nxt = rem_r - dsh_r;
      end
      quo_nxt = {quo_r[PIX_W-2:0], fits};
      dsh_nxt = dsh_r >> 1;
      if (step_r == STEP_W'(QSTEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        step_nxt = step_r + STEP_W'(1);
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dsh_r <= dsh_nxt;
    quo_r <= quo_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule

`default_nettype wire
